[rtl/tpsd_pkg.sv]
// Package of the TGA pixel stream decoder: types, constants and pixel format functions.
// Used by every module of the decoder; depends on nothing.
`default_nettype none

package tpsd_pkg;

	localparam int PALETTE_SIZE     = 256;
	localparam int PAL_AW           = $clog2(PALETTE_SIZE);
	localparam int PIXEL_COUNT_BITS = 24;
	localparam int COUNT_W          = PIXEL_COUNT_BITS + 1;
	localparam int TOTAL_W          = 25;

	localparam logic [31:0] OPAQUE_BLACK = 32'hff00_0000;

	localparam logic [1:0] MODE_TRUE = 2'd0;
	localparam logic [1:0] MODE_GRAY = 2'd1;
	localparam logic [1:0] MODE_MAP  = 2'd2;

	localparam logic [2:0] REG_IMAGE_MODE  = 3'd0;
	localparam logic [2:0] REG_RLE_ENABLE  = 3'd1;
	localparam logic [2:0] REG_PIXEL_DEPTH = 3'd2;
	localparam logic [2:0] REG_MAP_DEPTH   = 3'd3;
	localparam logic [2:0] REG_MAP_FIRST   = 3'd4;
	localparam logic [2:0] REG_MAP_ENTRIES = 3'd5;
	localparam logic [2:0] REG_PIXEL_TOTAL = 3'd6;

	typedef enum logic [1:0] {
		PH_MAP    = 2'd0,
		PH_HEADER = 2'd1,
		PH_PIXEL  = 2'd2,
		PH_SPARE  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]         image_mode;
		logic               rle_enable;
		logic [1:0]         pixel_depth_code;
		logic [1:0]         map_depth_code;
		logic [7:0]         map_first;
		logic [15:0]        map_entries;
		logic [TOTAL_W-1:0] pixel_total;
	} cfg_t;

	typedef struct packed {
		logic              wr_en;
		logic              clear;
		logic [PAL_AW-1:0] addr;
		logic [31:0]       data;
	} pal_wr_t;

	typedef struct packed {
		logic       from_gather;
		logic [7:0] gather_byte;
	} pal_rd_hint_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] pixel_argb;
		logic [7:0]  repeat_count;
		logic        last_pixel;
	} result_t;

	function automatic logic [31:0] widen(input logic [1:0] code, input logic [31:0] v);
		logic [31:0] rgb;
		logic [31:0] res;
		rgb = {8'h00, v[14:10], 3'b000, v[9:5], 3'b000, v[4:0], 3'b000};
		unique case (code)
			2'd0: res = OPAQUE_BLACK | rgb;
			2'd1: res = (v[15] ? OPAQUE_BLACK : 32'h0) | rgb;
			2'd2: res = OPAQUE_BLACK | {8'h00, v[23:0]};
			default: res = v;
		endcase
		return res;
	endfunction

	function automatic logic [2:0] depth_bytes(input logic [1:0] code);
		return (code < 2'd2) ? 3'd2 : {1'b0, code} + 3'd1;
	endfunction

endpackage

`default_nettype wire

[rtl/tpsd_cfg_regs.sv]
// Configuration register bank of the TGA pixel stream decoder.
// Depends on tpsd_pkg for the register indexes and the cfg_t type.
`default_nettype none

module tpsd_cfg_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [2:0]                   wr_index,
	input  wire logic [tpsd_pkg::TOTAL_W-1:0] wr_data,
	output tpsd_pkg::cfg_t                    cfg
);

	tpsd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_mode       <= tpsd_pkg::MODE_TRUE;
			cfg_q.rle_enable       <= 1'b0;
			cfg_q.pixel_depth_code <= 2'd2;
			cfg_q.map_depth_code   <= 2'd2;
			cfg_q.map_first        <= '0;
			cfg_q.map_entries      <= '0;
			cfg_q.pixel_total      <= tpsd_pkg::TOTAL_W'(1);
		end else if (wr_en) begin
			unique case (wr_index)
				tpsd_pkg::REG_IMAGE_MODE:  cfg_q.image_mode       <= wr_data[1:0];
				tpsd_pkg::REG_RLE_ENABLE:  cfg_q.rle_enable       <= wr_data[0];
				tpsd_pkg::REG_PIXEL_DEPTH: cfg_q.pixel_depth_code <= wr_data[1:0];
				tpsd_pkg::REG_MAP_DEPTH:   cfg_q.map_depth_code   <= wr_data[1:0];
				tpsd_pkg::REG_MAP_FIRST:   cfg_q.map_first        <= wr_data[7:0];
				tpsd_pkg::REG_MAP_ENTRIES: cfg_q.map_entries      <= wr_data[15:0];
				tpsd_pkg::REG_PIXEL_TOTAL: cfg_q.pixel_total      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[rtl/tpsd_palette.sv]
// Palette memory with per-entry valid bits, a write-to-read bypass and a registered read.
// Depends on tpsd_pkg for the palette size and the pal_wr_t type.
`default_nettype none

module tpsd_palette (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tpsd_pkg::pal_wr_t           wr,
	input  wire logic                        rd_en,
	input  wire logic [tpsd_pkg::PAL_AW-1:0] rd_addr,
	output logic [31:0]                      rd_data
);

	logic [31:0]                       mem [tpsd_pkg::PALETTE_SIZE];
	logic [tpsd_pkg::PALETTE_SIZE-1:0] valid_q;
	logic [31:0]                       rd_q;
	logic [31:0]                       byp_q;
	logic                              hit_q;
	logic                              vld_q;
	logic                              hit;

	assign hit = wr.wr_en && (wr.addr == rd_addr);

	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_q  <= mem[rd_addr];
			byp_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
			vld_q   <= 1'b0;
		end else begin
			if (wr.clear) begin
				valid_q <= '0;
			end else if (wr.wr_en) begin
				valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= hit;
				vld_q <= !wr.clear && (hit || valid_q[rd_addr]);
			end
		end
	end

	assign rd_data = !vld_q ? tpsd_pkg::OPAQUE_BLACK : (hit_q ? byp_q : rd_q);

endmodule

`default_nettype wire

[rtl/tpsd_decode.sv]
// Decode state and single-pass step logic: palette loading, packet headers and pixels.
// Depends on tpsd_pkg for the types, the constants and the pixel format functions.
`default_nettype none

module tpsd_decode (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tpsd_pkg::cfg_t       cfg,
	input  wire logic                 step_en,
	input  wire logic [7:0]           byte_in,
	input  wire logic [31:0]          pal_rdata,
	output tpsd_pkg::pal_wr_t         pal_wr,
	output tpsd_pkg::pal_rd_hint_t    rd_hint,
	output tpsd_pkg::result_t         result
);

	localparam int CW = tpsd_pkg::COUNT_W;
	localparam logic [CW-1:0] LIMIT = CW'(1) << tpsd_pkg::PIXEL_COUNT_BITS;

	tpsd_pkg::phase_t phase_q, phase_d;
	logic [31:0]      bg_q, bg_d;
	logic [1:0]       pos_q, pos_d;
	logic [7:0]       pl_q, pl_d;
	logic             run_q, run_d;
	logic [CW-1:0]    done_q, done_d;
	logic [15:0]      loaded_q, loaded_d;

	logic [CW-1:0] teff;
	logic [CW-1:0] left;
	logic          end_img;

	always_comb begin
		if (cfg.pixel_total == '0) begin
			teff = CW'(1);
		end else if (CW'(cfg.pixel_total) > LIMIT) begin
			teff = LIMIT;
		end else begin
			teff = CW'(cfg.pixel_total);
		end
		left = (teff > done_q) ? teff - done_q : CW'(1);
	end

	always_comb begin
		logic          map_act;
		logic [31:0]   g;
		logic [31:0]   bg_base;
		logic [1:0]    pos_base;
		logic [7:0]    pl_base;
		logic          run_base;
		logic [7:0]    pl0;
		logic [7:0]    rep;
		logic [7:0]    cnt;
		logic [2:0]    pbytes;
		logic [16:0]   idx;
		logic [7:0]    g8;
		logic [31:0]   value;
		logic [CW-1:0] done_new;
		logic          in_map_phase;

		phase_d  = phase_q;
		bg_d     = bg_q;
		pos_d    = pos_q;
		pl_d     = pl_q;
		run_d    = run_q;
		done_d   = done_q;
		loaded_d = loaded_q;
		end_img  = 1'b0;
		pal_wr   = '0;
		result   = '0;

		in_map_phase = (phase_q == tpsd_pkg::PH_MAP) || (phase_q == tpsd_pkg::PH_SPARE);
		map_act      = in_map_phase && (cfg.image_mode == tpsd_pkg::MODE_MAP)
		               && (loaded_q < cfg.map_entries);
		idx          = 17'(cfg.map_first) + 17'(loaded_q);
		cnt          = {1'b0, byte_in[6:0]} + 8'd1;
		pbytes       = ((cfg.image_mode == tpsd_pkg::MODE_GRAY)
		               || (cfg.image_mode == tpsd_pkg::MODE_MAP))
		               ? 3'd1 : tpsd_pkg::depth_bytes(cfg.pixel_depth_code);

		if (in_map_phase || (phase_q == tpsd_pkg::PH_HEADER && !cfg.rle_enable)) begin
			bg_base  = '0;
			pos_base = '0;
			pl_base  = 8'd1;
			run_base = 1'b0;
		end else begin
			bg_base  = bg_q;
			pos_base = pos_q;
			pl_base  = pl_q;
			run_base = run_q;
		end
		g   = bg_base | (32'(byte_in) << {pos_base, 3'b000});
		g8  = g[7:0];
		pl0 = (pl_base == '0) ? 8'd1 : pl_base;
		rep = run_base ? pl0 : 8'd1;
		if (CW'(rep) > left) begin
			rep = left[7:0];
		end
		done_new = done_q + CW'(rep);

		if ({1'b0, g8} < 9'(tpsd_pkg::PALETTE_SIZE)) begin
			value = pal_rdata;
		end else begin
			value = tpsd_pkg::OPAQUE_BLACK;
		end
		if (cfg.image_mode == tpsd_pkg::MODE_GRAY) begin
			value = tpsd_pkg::OPAQUE_BLACK | {8'h00, g8, g8, g8};
		end else if (cfg.image_mode != tpsd_pkg::MODE_MAP) begin
			value = tpsd_pkg::widen(cfg.pixel_depth_code, g);
		end

		if (map_act) begin
			g = bg_q | (32'(byte_in) << {pos_q, 3'b000});
			if ({1'b0, pos_q} + 3'd1 >= tpsd_pkg::depth_bytes(cfg.map_depth_code)) begin
				pal_wr.wr_en = step_en && (idx < 17'(tpsd_pkg::PALETTE_SIZE));
				pal_wr.addr  = idx[tpsd_pkg::PAL_AW-1:0];
				pal_wr.data  = tpsd_pkg::widen(cfg.map_depth_code, g);
				loaded_d     = loaded_q + 16'd1;
				bg_d         = '0;
				pos_d        = '0;
			end else begin
				bg_d  = g;
				pos_d = pos_q + 2'd1;
			end
		end else if ((in_map_phase || phase_q == tpsd_pkg::PH_HEADER) && cfg.rle_enable) begin
			pl_d    = (CW'(cnt) > left) ? left[7:0] : cnt;
			run_d   = byte_in[7];
			phase_d = tpsd_pkg::PH_PIXEL;
			bg_d    = '0;
			pos_d   = '0;
		end else if ({1'b0, pos_base} + 3'd1 < pbytes) begin
			bg_d    = g;
			pos_d   = pos_base + 2'd1;
			pl_d    = pl_base;
			run_d   = run_base;
			phase_d = tpsd_pkg::PH_PIXEL;
		end else begin
			result.valid        = 1'b1;
			result.pixel_argb   = value;
			result.repeat_count = rep;
			result.last_pixel   = done_new >= teff;
			bg_d                = '0;
			pos_d               = '0;
			run_d               = run_base;
			pl_d                = run_base ? 8'd0 : pl0 - 8'd1;
			done_d              = done_new;
			if (done_new >= teff) begin
				end_img  = 1'b1;
				phase_d  = tpsd_pkg::PH_MAP;
				pl_d     = '0;
				run_d    = 1'b0;
				done_d   = '0;
				loaded_d = '0;
			end else if (pl_d == '0) begin
				phase_d = tpsd_pkg::PH_HEADER;
			end else begin
				phase_d = tpsd_pkg::PH_PIXEL;
			end
		end
		pal_wr.clear = step_en && end_img;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= tpsd_pkg::PH_MAP;
			bg_q     <= '0;
			pos_q    <= '0;
			pl_q     <= '0;
			run_q    <= 1'b0;
			done_q   <= '0;
			loaded_q <= '0;
		end else if (step_en) begin
			phase_q  <= phase_d;
			bg_q     <= bg_d;
			pos_q    <= pos_d;
			pl_q     <= pl_d;
			run_q    <= run_d;
			done_q   <= done_d;
			loaded_q <= loaded_d;
		end
	end

	// The index of the next pixel comes from the gathered bytes when a gather is in progress.
	always_comb begin
		if (step_en) begin
			rd_hint.from_gather = (phase_d == tpsd_pkg::PH_PIXEL) && (pos_d != '0);
			rd_hint.gather_byte = bg_d[7:0];
		end else begin
			rd_hint.from_gather = (phase_q == tpsd_pkg::PH_PIXEL) && (pos_q != '0);
			rd_hint.gather_byte = bg_q[7:0];
		end
	end

endmodule

`default_nettype wire

[rtl/tga_pixel_stream_decoder_core.sv]
// TGA pixel stream decoder top level: config registers, input register, decode step, palette and result register.
// A byte that completes a pixel passes from the input register through the decode step into the result register.
// Throughput: one byte per cycle while the result register is not blocked by m_tready.
// Reset clears all control state and marks every palette entry as opaque black at once.
// Depends on tpsd_pkg, tpsd_cfg_regs, tpsd_palette and tpsd_decode.
`default_nettype none

module tga_pixel_stream_decoder_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [7:0]                   s_tdata,   // [7:0] data_byte
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [39:0]                       m_tdata,   // [31:0] pixel_argb, [39:32] repeat_count
	output logic                              m_tlast,   // last_pixel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [tpsd_pkg::TOTAL_W-1:0] cfg_data
);

	tpsd_pkg::cfg_t         cfg;
	tpsd_pkg::pal_wr_t      pal_wr;
	tpsd_pkg::pal_rd_hint_t rd_hint;
	tpsd_pkg::result_t      result;

	logic        s1_valid;
	logic [7:0]  byte_s1;
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_last_q;
	logic        advance;
	logic        accept;
	logic [31:0] pal_rdata;
	logic [7:0]  rd_byte;

	assign advance   = s1_valid && (!out_valid_q || m_tready);
	assign s_tready  = !s1_valid || advance;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	tpsd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign rd_byte = rd_hint.from_gather ? rd_hint.gather_byte : s_tdata;

	tpsd_palette u_pal (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (pal_wr),
		.rd_en   (accept),
		.rd_addr (rd_byte[tpsd_pkg::PAL_AW-1:0]),
		.rd_data (pal_rdata)
	);

	tpsd_decode u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step_en   (advance),
		.byte_in   (byte_s1),
		.pal_rdata (pal_rdata),
		.pal_wr    (pal_wr),
		.rd_hint   (rd_hint),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_tdata;
		end
		if (advance && result.valid) begin
			out_data_q <= {result.repeat_count, result.pixel_argb};
			out_last_q <= result.last_pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= result.valid;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	a_repeat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[39:32] != 8'd0) && (m_tdata[39:32] <= 8'd128))
		else $error("repeat count out of range");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid && out_valid_q && !m_tready) |=> (s1_valid && $stable(byte_s1)))
		else $error("input stage moved while the result register was blocked");

	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(pal_wr.clear && pal_wr.wr_en))
		else $error("palette clear and entry write in the same cycle");

endmodule

`default_nettype wire
